// ===== hw/rtl/llx_pkg.sv =====
`default_nettype none

package llx_pkg;

    // Character classes, decided by the front end
    localparam logic [3:0] CLS_SPACE   = 4'd0;
    localparam logic [3:0] CLS_NEWLINE = 4'd1;
    localparam logic [3:0] CLS_UPPER   = 4'd2;
    localparam logic [3:0] CLS_LOWER   = 4'd3;
    localparam logic [3:0] CLS_DIGIT   = 4'd4;
    localparam logic [3:0] CLS_UNDER   = 4'd5;
    localparam logic [3:0] CLS_COLON   = 4'd6;
    localparam logic [3:0] CLS_MINUS   = 4'd7;
    localparam logic [3:0] CLS_EQUAL   = 4'd8;
    localparam logic [3:0] CLS_PUNCT   = 4'd9;
    localparam logic [3:0] CLS_OTHER   = 4'd10;

    // Token kinds
    localparam logic [4:0] TK_BEGIN   = 5'd0;
    localparam logic [4:0] TK_END     = 5'd1;
    localparam logic [4:0] TK_READ    = 5'd2;
    localparam logic [4:0] TK_WRITE   = 5'd3;
    localparam logic [4:0] TK_ID      = 5'd4;
    localparam logic [4:0] TK_INT     = 5'd5;
    localparam logic [4:0] TK_LPAREN  = 5'd6;
    localparam logic [4:0] TK_RPAREN  = 5'd7;
    localparam logic [4:0] TK_SEMI    = 5'd8;
    localparam logic [4:0] TK_COMMA   = 5'd9;
    localparam logic [4:0] TK_ASSIGN  = 5'd10;
    localparam logic [4:0] TK_PLUS    = 5'd11;
    localparam logic [4:0] TK_MINUS   = 5'd12;
    localparam logic [4:0] TK_EOF     = 5'd13;
    localparam logic [4:0] TK_PIPE    = 5'd14;
    localparam logic [4:0] TK_ERROR   = 5'd15;
    localparam logic [4:0] TK_TOOLONG = 5'd16;

    localparam logic [5:0] LEN_MAX       = 6'd63;
    localparam logic [5:0] MAX_LEN_RESET = 6'd32;

    // Classified beat passed from front to back
    typedef struct packed {
        logic       eoi;
        logic [3:0] cls;
        logic [4:0] kind;
        logic [7:0] ch;
    } item_t;

    // One result
    typedef struct packed {
        logic [4:0] kind;
        logic [5:0] len;
        logic [7:0] off;
    } res_t;

    // All results of one item: one, or two when two is set
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/micro_language_lexer.sv =====
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// source   | s_valid s_ready s_character s_end_of_input   | in
// tokens   | m_valid m_ready m_token_kind m_lexeme_length | out
//          | m_offending_char m_last                      |
// config   | cfg_wr_en cfg_wr_data                        | in
//
// One source beat per cycle is taken while the input queue has room; the input
// queue registers it before the scanner, and the output queue registers its
// results before m_. Each token beat takes one output cycle while m_ready is
// high, so a byte that flushes a pending token and gives one of its own (or an
// end mark after a pending token) gives two beats; the output queue absorbs this.
// Input and output stall independently through the two queues.
// Reset (aresetn low, synchronous) empties both queues and returns the scanner
// to idle with max_identifier_length at 32.
`default_nettype none

module micro_language_lexer #(
    parameter int KEYWORD_CHARS   = 5,
    parameter int LENGTH_LIMIT    = 63,
    parameter int IN_QUEUE_DEPTH  = 4,
    parameter int OUT_QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_character,
    input  wire logic       s_end_of_input,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [4:0]      m_token_kind,
    output logic [5:0]      m_lexeme_length,
    output logic [7:0]      m_offending_char,
    output logic            m_last,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data
);

    logic [5:0]     max_len_reg;
    logic           slot_reg, slot_next;

    logic           fr_valid, fr_ready;
    llx_pkg::item_t fr_item;
    logic           iq_valid, iq_ready;
    llx_pkg::item_t iq_item;
    logic           sc_valid, sc_ready;
    llx_pkg::pair_t sc_pair;
    logic           oq_valid, oq_ready;
    llx_pkg::pair_t oq_pair;
    llx_pkg::res_t  cur_res;

    // Hold the identifier length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= llx_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    llx_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_end_of_input (s_end_of_input),
        .item_valid     (fr_valid),
        .item_ready     (fr_ready),
        .item           (fr_item)
    );

    llx_fifo #(
        .WIDTH ($bits(llx_pkg::item_t)),
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_in_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_item),
        .rd_valid (iq_valid),
        .rd_ready (iq_ready),
        .rd_data  (iq_item)
    );

    llx_scan #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_LIMIT  (LENGTH_LIMIT)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_len   (max_len_reg),
        .in_valid  (iq_valid),
        .in_ready  (iq_ready),
        .in_item   (iq_item),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_pair  (sc_pair)
    );

    llx_fifo #(
        .WIDTH ($bits(llx_pkg::pair_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (sc_valid),
        .wr_ready (sc_ready),
        .wr_data  (sc_pair),
        .rd_valid (oq_valid),
        .rd_ready (oq_ready),
        .rd_data  (oq_pair)
    );

    // Unpack a queued pair into one or two token beats
    always_comb begin
        cur_res          = slot_reg ? oq_pair.r1 : oq_pair.r0;
        m_valid          = oq_valid;
        m_token_kind     = cur_res.kind;
        m_lexeme_length  = cur_res.len;
        m_offending_char = cur_res.off;
        m_last           = slot_reg || !oq_pair.two;
        oq_ready         = m_ready && m_last;
        slot_next        = slot_reg;
        if (m_valid && m_ready) begin
            slot_next = !m_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    // Second slot is only ever selected on a queued two-token pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg |-> (oq_valid && oq_pair.two))
        else $error("second token slot selected without a two-token pair");

    // Scanner never consumes a beat the output queue cannot hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        (iq_valid && iq_ready) |-> sc_ready)
        else $error("scanner advanced while output queue full");

    // A two-token pair pops only after both tokens went out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (oq_valid && oq_ready && oq_pair.two) |-> slot_reg)
        else $error("two-token pair dropped before its second token");

endmodule

`default_nettype wire

// ===== hw/rtl/llx_fifo.sv =====
`default_nettype none

module llx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers, wrapping at the last entry, and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/llx_front.sv =====
`default_nettype none

module llx_front (
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_character,
    input  wire logic         s_end_of_input,
    output logic              item_valid,
    input  wire logic         item_ready,
    output llx_pkg::item_t    item
);

    // Sort a byte into its class; single-character tokens get their kind here
    function automatic llx_pkg::item_t classify(input logic [7:0] c, input logic eoi);
        llx_pkg::item_t r;
        r.eoi  = eoi;
        r.ch   = c;
        r.kind = llx_pkg::TK_ERROR;
        if (c >= "A" && c <= "Z") begin
            r.cls = llx_pkg::CLS_UPPER;
        end else if (c >= "a" && c <= "z") begin
            r.cls = llx_pkg::CLS_LOWER;
        end else if (c >= "0" && c <= "9") begin
            r.cls = llx_pkg::CLS_DIGIT;
        end else if (c == 8'd10) begin
            r.cls = llx_pkg::CLS_NEWLINE;
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            r.cls = llx_pkg::CLS_SPACE;
        end else begin
            r.cls = llx_pkg::CLS_PUNCT;
            case (c)
                "|":     r.kind = llx_pkg::TK_PIPE;
                "(":     r.kind = llx_pkg::TK_LPAREN;
                ")":     r.kind = llx_pkg::TK_RPAREN;
                ";":     r.kind = llx_pkg::TK_SEMI;
                ",":     r.kind = llx_pkg::TK_COMMA;
                "+":     r.kind = llx_pkg::TK_PLUS;
                ":":     r.cls = llx_pkg::CLS_COLON;
                "-":     r.cls = llx_pkg::CLS_MINUS;
                "=":     r.cls = llx_pkg::CLS_EQUAL;
                "_":     r.cls = llx_pkg::CLS_UNDER;
                default: r.cls = llx_pkg::CLS_OTHER;
            endcase
        end
        return r;
    endfunction

    // Pass the classified beat straight into the queue
    assign item       = classify(s_character, s_end_of_input);
    assign item_valid = s_valid;
    assign s_ready    = item_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/llx_scan.sv =====
`default_nettype none

module llx_scan #(
    parameter int KEYWORD_CHARS = 5,
    parameter int LENGTH_LIMIT  = 63
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [5:0]     max_len,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire llx_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output llx_pkg::pair_t      out_pair
);

    localparam int CW  = $clog2(LENGTH_LIMIT + 1);
    localparam int KIW = $clog2(KEYWORD_CHARS);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_COLON   = 3'd3;
    localparam logic [2:0] MODE_MINUS   = 3'd4;
    localparam logic [2:0] MODE_COMMENT = 3'd5;

    localparam logic [39:0] KW_BEGIN = "BEGIN";
    localparam logic [23:0] KW_END   = "END";
    localparam logic [31:0] KW_READ  = "READ";
    localparam logic [39:0] KW_WRITE = "WRITE";

    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    flags_reg, flags_next;
    logic [7:0]    pfx_reg [KEYWORD_CHARS];

    logic          fire;
    logic          idle_emit, idle_start;
    logic [2:0]    idle_mode;
    llx_pkg::res_t idle_res;
    logic          pend_emit, tail_emit, use_idle, take, start, grow;
    llx_pkg::res_t pend_res, tail_res, id_res, int_res, err_colon_res, simple_res;
    logic [39:0]   up_word;
    logic [4:0]    id_kind;
    logic [5:0]    sat_len;
    logic [CW-1:0] base_cnt;
    logic [1:0]    base_flags;
    logic          pfx_we;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    assign fire     = in_valid && out_ready;
    assign in_ready = out_ready;

    // Classify the pending lexeme as keyword, identifier or too long
    always_comb begin
        up_word = {upcase(pfx_reg[0]), upcase(pfx_reg[1]), upcase(pfx_reg[2]),
                   upcase(pfx_reg[3]), upcase(pfx_reg[4])};
        sat_len = (cnt_reg > CW'(llx_pkg::LEN_MAX)) ? llx_pkg::LEN_MAX : cnt_reg[5:0];
        if (cnt_reg > CW'(max_len)) begin
            id_kind = llx_pkg::TK_TOOLONG;
        end else if (flags_reg == 2'b00) begin
            id_kind = llx_pkg::TK_ID;
        end else if (cnt_reg == CW'(5) && up_word == KW_BEGIN) begin
            id_kind = llx_pkg::TK_BEGIN;
        end else if (cnt_reg == CW'(3) && up_word[39:16] == KW_END) begin
            id_kind = llx_pkg::TK_END;
        end else if (cnt_reg == CW'(4) && up_word[39:8] == KW_READ) begin
            id_kind = llx_pkg::TK_READ;
        end else if (cnt_reg == CW'(5) && up_word == KW_WRITE) begin
            id_kind = llx_pkg::TK_WRITE;
        end else begin
            id_kind = llx_pkg::TK_ID;
        end
        id_res        = '{kind: id_kind, len: sat_len, off: 8'd0};
        int_res       = '{kind: llx_pkg::TK_INT, len: sat_len, off: 8'd0};
        err_colon_res = '{kind: llx_pkg::TK_ERROR, len: 6'd0, off: ":"};
        simple_res    = '{kind: llx_pkg::TK_MINUS, len: 6'd0, off: 8'd0};
    end

    // Work out what the current byte does when scanned from idle
    always_comb begin
        idle_emit  = 1'b0;
        idle_start = 1'b0;
        idle_mode  = MODE_IDLE;
        idle_res   = '{kind: in_item.kind, len: 6'd0, off: 8'd0};
        case (in_item.cls)
            llx_pkg::CLS_SPACE, llx_pkg::CLS_NEWLINE: begin
                idle_mode = MODE_IDLE;
            end
            llx_pkg::CLS_UPPER, llx_pkg::CLS_LOWER: begin
                idle_start = 1'b1;
                idle_mode  = MODE_IDENT;
            end
            llx_pkg::CLS_DIGIT: begin
                idle_start = 1'b1;
                idle_mode  = MODE_NUMBER;
            end
            llx_pkg::CLS_PUNCT: begin
                idle_emit = 1'b1;
            end
            llx_pkg::CLS_COLON: begin
                idle_mode = MODE_COLON;
            end
            llx_pkg::CLS_MINUS: begin
                idle_mode = MODE_MINUS;
            end
            default: begin
                idle_emit = 1'b1;
                idle_res  = '{kind: llx_pkg::TK_ERROR, len: 6'd0, off: in_item.ch};
            end
        endcase
    end

    // Step the scanner: a pending token first, then the byte's own result
    always_comb begin
        pend_emit = 1'b0;
        pend_res  = id_res;
        tail_emit = 1'b0;
        tail_res  = idle_res;
        use_idle  = 1'b0;
        take      = 1'b0;
        start     = 1'b0;
        mode_next = mode_reg;
        if (in_item.eoi) begin
            case (mode_reg)
                MODE_IDENT: begin
                    pend_emit = 1'b1;
                end
                MODE_NUMBER: begin
                    pend_emit = 1'b1;
                    pend_res  = int_res;
                end
                MODE_COLON: begin
                    pend_emit = 1'b1;
                    pend_res  = err_colon_res;
                end
                MODE_MINUS: begin
                    pend_emit = 1'b1;
                    pend_res  = simple_res;
                end
                default: begin
                    pend_emit = 1'b0;
                end
            endcase
            tail_emit = 1'b1;
            tail_res  = '{kind: llx_pkg::TK_EOF, len: 6'd0, off: 8'd0};
            mode_next = MODE_IDLE;
        end else begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (in_item.cls == llx_pkg::CLS_UPPER || in_item.cls == llx_pkg::CLS_LOWER ||
                        in_item.cls == llx_pkg::CLS_DIGIT || in_item.cls == llx_pkg::CLS_UNDER)
                    begin
                        take = 1'b1;
                    end else begin
                        pend_emit = 1'b1;
                        use_idle  = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (in_item.cls == llx_pkg::CLS_DIGIT) begin
                        take = 1'b1;
                    end else begin
                        pend_emit = 1'b1;
                        pend_res  = int_res;
                        use_idle  = 1'b1;
                    end
                end
                MODE_COLON: begin
                    if (in_item.cls == llx_pkg::CLS_EQUAL) begin
                        tail_emit = 1'b1;
                        tail_res  = '{kind: llx_pkg::TK_ASSIGN, len: 6'd0, off: 8'd0};
                        mode_next = MODE_IDLE;
                    end else begin
                        pend_emit = 1'b1;
                        pend_res  = err_colon_res;
                        use_idle  = 1'b1;
                    end
                end
                MODE_MINUS: begin
                    if (in_item.cls == llx_pkg::CLS_MINUS) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        pend_emit = 1'b1;
                        pend_res  = simple_res;
                        use_idle  = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (in_item.cls == llx_pkg::CLS_NEWLINE) begin
                        mode_next = MODE_IDLE;
                    end
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase
            if (use_idle) begin
                tail_emit = idle_emit;
                tail_res  = idle_res;
                mode_next = idle_mode;
                start     = idle_start;
            end
        end
    end

    // Pack the results of this beat
    always_comb begin
        out_valid   = in_valid && (pend_emit || tail_emit);
        out_pair.two = pend_emit && tail_emit;
        out_pair.r0  = pend_emit ? pend_res : tail_res;
        out_pair.r1  = tail_res;
    end

    // Grow the lexeme: count, case flags and keyword prefix
    always_comb begin
        grow       = take || start;
        base_cnt   = start ? '0 : cnt_reg;
        base_flags = start ? 2'b11 : flags_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        if (grow) begin
            cnt_next   = (base_cnt < CW'(LENGTH_LIMIT)) ? base_cnt + CW'(1) : base_cnt;
            flags_next = base_flags & {in_item.cls == llx_pkg::CLS_LOWER,
                                       in_item.cls == llx_pkg::CLS_UPPER};
        end
        pfx_we = fire && grow && (base_cnt < CW'(KEYWORD_CHARS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            cnt_reg   <= '0;
            flags_reg <= 2'b11;
        end else if (fire) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pfx_we) begin
            pfx_reg[base_cnt[KIW-1:0]] <= in_item.ch;
        end
    end

endmodule

`default_nettype wire

// ===== sim/micro_language_lexer_checker.sv =====
`timescale 1ns / 100ps

module micro_language_lexer_checker #(
    parameter int KEYWORD_CHARS = 5,
    parameter int LENGTH_LIMIT  = 63
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_character,
    input  wire logic       s_end_of_input,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [4:0] m_token_kind,
    input  wire logic [5:0] m_lexeme_length,
    input  wire logic [7:0] m_offending_char,
    input  wire logic       m_last,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data,
    output int              outstanding,
    output int              mismatches
);

    localparam logic [7:0] CH_PIPE     = 8'h7C;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam int         PRINT_CAP   = 100;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_COLON,
        SCAN_MINUS,
        SCAN_COMMENT
    } scan_mode_e;

    typedef struct packed {
        logic [4:0] kind;
        logic [5:0] len;
        logic [7:0] off;
        logic       last;
    } token_beat_t;

    // Expected token beats, oldest first
    token_beat_t token_q[$];

    // Scanner state mirror
    scan_mode_e  scan_mode;
    int          lexeme_count;
    logic [7:0]  name_head [KEYWORD_CHARS];
    logic        all_upper;
    logic        all_lower;
    logic [5:0]  max_ident_len;
    int          beats_made;

    function automatic bit is_upper(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_lower(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return is_upper(c) || is_lower(c);
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void push_token(input logic [4:0] kind, input int len,
                                       input logic [7:0] off);
        token_beat_t t;
        t.kind = kind;
        t.len  = (len > llx_pkg::LEN_MAX) ? llx_pkg::LEN_MAX : 6'(len);
        t.off  = off;
        t.last = 1'b0;
        token_q.push_back(t);
        beats_made++;
    endfunction

    // Add one character to the current lexeme and track its case
    function automatic void take_char(input logic [7:0] c);
        if (lexeme_count < KEYWORD_CHARS)
            name_head[lexeme_count] = c;
        if (lexeme_count < LENGTH_LIMIT)
            lexeme_count++;
        if (!is_upper(c))
            all_upper = 1'b0;
        if (!is_lower(c))
            all_lower = 1'b0;
    endfunction

    function automatic void start_lexeme(input logic [7:0] c, input scan_mode_e mode);
        lexeme_count = 0;
        all_upper    = 1'b1;
        all_lower    = 1'b1;
        take_char(c);
        scan_mode = mode;
    endfunction

    // True when the held name spells the word, ignoring a uniform case
    function automatic bit spells(input string word);
        logic [7:0] c;
        if (lexeme_count != word.len() || word.len() > KEYWORD_CHARS)
            return 1'b0;
        for (int i = 0; i < word.len(); i++) begin
            c = name_head[i];
            if (is_lower(c))
                c = c - CASE_OFFSET;
            if (c != word[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [4:0] name_kind();
        if (lexeme_count > max_ident_len)
            return llx_pkg::TK_TOOLONG;
        if (!all_upper && !all_lower)
            return llx_pkg::TK_ID;
        if (spells("BEGIN"))
            return llx_pkg::TK_BEGIN;
        if (spells("END"))
            return llx_pkg::TK_END;
        if (spells("READ"))
            return llx_pkg::TK_READ;
        if (spells("WRITE"))
            return llx_pkg::TK_WRITE;
        return llx_pkg::TK_ID;
    endfunction

    // Scan a character from the idle mode
    function automatic void scan_fresh(input logic [7:0] c);
        scan_mode = SCAN_IDLE;
        if (is_space(c))
            return;
        if (is_letter(c)) begin
            start_lexeme(c, SCAN_IDENT);
            return;
        end
        if (is_digit(c)) begin
            start_lexeme(c, SCAN_NUMBER);
            return;
        end
        case (c)
            CH_PIPE:   push_token(llx_pkg::TK_PIPE, 0, 8'd0);
            CH_LPAREN: push_token(llx_pkg::TK_LPAREN, 0, 8'd0);
            CH_RPAREN: push_token(llx_pkg::TK_RPAREN, 0, 8'd0);
            CH_SEMI:   push_token(llx_pkg::TK_SEMI, 0, 8'd0);
            CH_COMMA:  push_token(llx_pkg::TK_COMMA, 0, 8'd0);
            CH_PLUS:   push_token(llx_pkg::TK_PLUS, 0, 8'd0);
            CH_COLON:  scan_mode = SCAN_COLON;
            CH_MINUS:  scan_mode = SCAN_MINUS;
            default:   push_token(llx_pkg::TK_ERROR, 0, c);
        endcase
    endfunction

    // Work out the token beats that one source beat causes
    function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
        token_beat_t t;
        beats_made = 0;
        if (eoi) begin
            case (scan_mode)
                SCAN_IDENT:  push_token(name_kind(), lexeme_count, 8'd0);
                SCAN_NUMBER: push_token(llx_pkg::TK_INT, lexeme_count, 8'd0);
                SCAN_COLON:  push_token(llx_pkg::TK_ERROR, 0, CH_COLON);
                SCAN_MINUS:  push_token(llx_pkg::TK_MINUS, 0, 8'd0);
                default: ;
            endcase
            push_token(llx_pkg::TK_EOF, 0, 8'd0);
            scan_mode = SCAN_IDLE;
        end else begin
            case (scan_mode)
                SCAN_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                        take_char(c);
                    end else begin
                        push_token(name_kind(), lexeme_count, 8'd0);
                        scan_fresh(c);
                    end
                end
                SCAN_NUMBER: begin
                    if (is_digit(c)) begin
                        take_char(c);
                    end else begin
                        push_token(llx_pkg::TK_INT, lexeme_count, 8'd0);
                        scan_fresh(c);
                    end
                end
                SCAN_COLON: begin
                    if (c == CH_EQUAL) begin
                        push_token(llx_pkg::TK_ASSIGN, 0, 8'd0);
                        scan_mode = SCAN_IDLE;
                    end else begin
                        push_token(llx_pkg::TK_ERROR, 0, CH_COLON);
                        scan_fresh(c);
                    end
                end
                SCAN_MINUS: begin
                    if (c == CH_MINUS) begin
                        scan_mode = SCAN_COMMENT;
                    end else begin
                        push_token(llx_pkg::TK_MINUS, 0, 8'd0);
                        scan_fresh(c);
                    end
                end
                SCAN_COMMENT: begin
                    if (c == CH_NEWLINE)
                        scan_mode = SCAN_IDLE;
                end
                default: scan_fresh(c);
            endcase
        end
        // Flag the final beat of this item
        if (beats_made > 0) begin
            t = token_q.pop_back();
            t.last = 1'b1;
            token_q.push_back(t);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Compare result beats, then fold in source beats and register writes
    always @(posedge aclk) begin
        token_beat_t want;
        if (!aresetn) begin
            token_q.delete();
            scan_mode     = SCAN_IDLE;
            lexeme_count  = 0;
            all_upper     = 1'b1;
            all_lower     = 1'b1;
            max_ident_len = llx_pkg::MAX_LEN_RESET;
            for (int i = 0; i < KEYWORD_CHARS; i++)
                name_head[i] = 8'd0;
        end else begin
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("token beat kind %0d with none expected",
                                              m_token_kind));
                end else begin
                    want = token_q.pop_front();
                    if (m_token_kind !== want.kind)
                        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                                  m_token_kind, want.kind));
                    if (m_lexeme_length !== want.len)
                        report_mismatch($sformatf("lexeme_length %0d, expected %0d",
                                                  m_lexeme_length, want.len));
                    if (m_offending_char !== want.off)
                        report_mismatch($sformatf("offending_char %0d, expected %0d",
                                                  m_offending_char, want.off));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d",
                                                  m_last, want.last));
                end
            end
            if (s_valid && s_ready)
                predict_tokens(s_character, s_end_of_input);
            if (cfg_wr_en)
                max_ident_len = cfg_wr_data;
        end
        outstanding <= token_q.size();
    end

endmodule

// ===== sim/tb_micro_language_lexer.sv =====
`timescale 1ns / 100ps

module tb_micro_language_lexer;

    localparam int KEYWORD_CHARS  = 5;
    localparam int LENGTH_LIMIT   = 63;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 1400;
    localparam int PHASE_ITEMS    = 220;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [5:0] MAX_LEN_LOW  = 6'd1;
    localparam logic [5:0] MAX_LEN_HIGH = 6'd62;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_character      = 8'd0;
    logic       s_end_of_input   = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [4:0] m_token_kind;
    logic [5:0] m_lexeme_length;
    logic [7:0] m_offending_char;
    logic       m_last;
    logic       cfg_wr_en        = 1'b0;
    logic [5:0] cfg_wr_data      = 6'd0;

    int outstanding;
    int mismatches;
    int items_sent  = 0;
    int cycle_count = 0;
    int sink_hold   = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;

    micro_language_lexer #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_LIMIT  (LENGTH_LIMIT)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_character      (s_character),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_lexeme_length  (m_lexeme_length),
        .m_offending_char (m_offending_char),
        .m_last           (m_last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    micro_language_lexer_checker #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_LIMIT  (LENGTH_LIMIT)
    ) token_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_character      (s_character),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_lexeme_length  (m_lexeme_length),
        .m_offending_char (m_offending_char),
        .m_last           (m_last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .outstanding      (outstanding),
        .mismatches       (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_cycles(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the token side at random; switch stretches of no idling on and off
    always @(posedge aclk) begin
        int stall;
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) begin
            src_steady  <= ($urandom_range(0, 3) == 0);
            sink_steady <= ($urandom_range(0, 3) == 0);
        end
        if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            stall = gap_cycles(sink_steady);
            m_ready   <= (stall == 0);
            sink_hold <= (stall > 0) ? stall - 1 : 0;
        end
    end

    // Present one source beat and hold it until accepted
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int gap;
        gap = gap_cycles(src_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_character    <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_beat(text[i], 1'b0);
    endtask

    task automatic send_end_mark();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Close the phase and wait until every token beat has drained
    task automatic finish_phase();
        send_end_mark();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'("A" + $urandom_range(0, 25));
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 52)
            return rand_letter();
        if (r < 62)
            return 8'("0" + $urandom_range(0, 9));
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return CH_SPACE;
        return CH_TAB + 8'(r - 1);
    endfunction

    // Name length: mostly short, some around the limit, a few past saturation
    function automatic int name_length(input logic [5:0] max_len);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95) begin
            n = int'(max_len) + $urandom_range(0, 3) - 1;
            return (n < 1) ? 1 : n;
        end
        return $urandom_range(60, 70);
    endfunction

    // Send one well-formed lexeme with random content, or some noise
    task automatic send_random_lexeme(input logic [5:0] max_len);
        int    r;
        int    n;
        int    style;
        string word;
        string punct;
        logic [7:0] c;
        punct = "|();,+";
        r = $urandom_range(0, 99);
        if (r < 22) begin
            n = name_length(max_len);
            send_beat(rand_letter(), 1'b0);
            for (int i = 1; i < n; i++)
                send_beat(rand_name_char(), 1'b0);
        end else if (r < 34) begin
            case ($urandom_range(0, 3))
                0: word = "BEGIN";
                1: word = "END";
                2: word = "READ";
                default: word = "WRITE";
            endcase
            style = $urandom_range(0, 2);
            for (int i = 0; i < word.len(); i++) begin
                c = word[i];
                if (style == 1 || (style == 2 && $urandom_range(0, 1)))
                    c = c + CASE_OFFSET;
                send_beat(c, 1'b0);
            end
        end else if (r < 50) begin
            n = ($urandom_range(0, 99) < 96) ? $urandom_range(1, 6) : $urandom_range(60, 70);
            for (int i = 0; i < n; i++)
                send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (r < 68) begin
            n = $urandom_range(0, 7);
            if (n < 6)
                send_beat(punct[n], 1'b0);
            else if (n == 6)
                send_text(":=");
            else
                send_beat(CH_MINUS, 1'b0);
        end else if (r < 74) begin
            // Comment; sometimes left open so it swallows what follows
            send_text("--");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(0, 255));
                send_beat((c == CH_NEWLINE) ? CH_SPACE : c, 1'b0);
            end
            if ($urandom_range(0, 4) != 0)
                send_beat(CH_NEWLINE, 1'b0);
        end else if (r < 80) begin
            send_beat(CH_COLON, 1'b0);
        end else if (r < 88) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 90) begin
            send_end_mark();
        end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                send_beat(rand_space(), 1'b0);
        end
        if ($urandom_range(0, 1))
            send_beat(rand_space(), 1'b0);
    endtask

    // Reset, directed text, then random phases over several limits
    initial begin
        int         phase;
        int         phase_start;
        logic [5:0] setting;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Keywords, every punctuator, unknown high byte, colon pending at end
        send_text("BEGIN(end:=7)-x;");
        send_beat(8'hFF, 1'b0);
        send_text(",+|:");
        finish_phase();
        // Mixed-case name, then a comment cut off by end of input
        send_text("rEAD--c");
        finish_phase();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: setting = MAX_LEN_LOW;
                1: setting = MAX_LEN_HIGH;
                2: setting = llx_pkg::MAX_LEN_RESET;
                default: setting = 6'($urandom_range(MAX_LEN_LOW, MAX_LEN_HIGH));
            endcase
            write_max_len(setting);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
                send_random_lexeme(setting);
            finish_phase();
            phase++;
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== micro_language_lexer.f =====
hw/rtl/llx_pkg.sv
hw/rtl/llx_fifo.sv
hw/rtl/llx_front.sv
hw/rtl/llx_scan.sv
hw/rtl/micro_language_lexer.sv
sim/micro_language_lexer_checker.sv
sim/tb_micro_language_lexer.sv
